@@ sv/drt_pkg.sv @@
// Shared types, codes and constants of the divider and reload timer.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package drt_pkg;

  // Default divider period in machine cycles.
  localparam int unsigned DivPeriodDefault = 256;

  // The counter prescaler holds up to 1023 and takes up to 255 more in one tick.
  localparam int unsigned CntPreW = 11;

  localparam int unsigned CtrlEnableBit = 2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REG_DIV     = 2'd0,
    REG_COUNT   = 2'd1,
    REG_RELOAD  = 2'd2,
    REG_CONTROL = 2'd3
  } reg_sel_e;

  typedef enum logic [1:0] {
    RATE_1024 = 2'd0,
    RATE_16   = 2'd1,
    RATE_64   = 2'd2,
    RATE_256  = 2'd3
  } rate_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] reg_select;
    logic [7:0] write_byte;
    logic [7:0] elapsed_cycles;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       irq_request;
  } out_beat_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic access;      // Register read or write: load result, apply write.
    logic tick_start;  // Add the elapsed cycles to the divider prescaler and, if enabled, the counter prescaler.
    logic tick_step;   // Take one period off each prescaler that holds one.
    logic tick_finish; // Load the tick result into the output register.
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic steps_pending;
  } dp_status_t;

  // Counter period chosen by control bits 1:0.
  function automatic logic [CntPreW-1:0] count_period(input logic [1:0] rate);
    logic [CntPreW-1:0] p;
    unique case (rate)
      RATE_1024: p = CntPreW'(1024);
      RATE_16:   p = CntPreW'(16);
      RATE_64:   p = CntPreW'(64);
      RATE_256:  p = CntPreW'(256);
      default:   p = CntPreW'(1024);
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ sv/drt_ctrl.sv @@
// Sequencer of the divider and reload timer: handshakes and tick stepping.
// Depends on drt_pkg.
`default_nettype none

module drt_ctrl
  import drt_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [1:0] in_cmd_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output dp_cmd_t         dp_cmd_o,
  input  wire dp_status_t dp_status_i
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The output register is free when empty or being emptied this cycle.
  assign can_load = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    dp_cmd_o    = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = !can_load;
        if (in_valid_i && can_load) begin
          if (in_cmd_i == CMD_TICK) begin
            dp_cmd_o.tick_start = 1'b1;
            state_d             = ST_RUN;
          end else begin
            dp_cmd_o.access = 1'b1;
            out_valid_d     = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (dp_status_i.steps_pending) begin
          dp_cmd_o.tick_step = 1'b1;
        end else if (can_load) begin
          dp_cmd_o.tick_finish = 1'b1;
          out_valid_d          = 1'b1;
          state_d              = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

@@ sv/drt_dp.sv @@
// Datapath of the divider and reload timer: the four timer bytes, both
// prescalers, the interrupt flag and the output register. Depends on drt_pkg.
`default_nettype none

module drt_dp
  import drt_pkg::*;
#(
  parameter int unsigned DIV_PERIOD = DivPeriodDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire in_beat_t   in_beat_i,
  input  wire dp_cmd_t    dp_cmd_i,
  output dp_status_t      dp_status_o,
  output out_beat_t       out_beat_o
);

  // Wide enough for a remainder below the period plus one full tick.
  localparam int unsigned DivPreW = $clog2(DIV_PERIOD + 256);

  logic [DivPreW-1:0] div_pre_q;
  logic [7:0]         div_q;
  logic [CntPreW-1:0] cnt_pre_q;
  logic [7:0]         count_q;
  logic [7:0]         reload_q;
  logic [7:0]         control_q;
  logic               irq_q;
  out_beat_t          out_q;

  logic               enabled;
  logic [CntPreW-1:0] period;
  logic               div_due;
  logic               cnt_due;
  logic [7:0]         rd_byte;

  assign enabled = control_q[CtrlEnableBit];
  assign period  = count_period(control_q[1:0]);
  assign div_due = div_pre_q >= DivPreW'(DIV_PERIOD);
  assign cnt_due = enabled && (cnt_pre_q >= period);

  assign dp_status_o.steps_pending = div_due || cnt_due;

  always_comb begin
    unique case (in_beat_i.reg_select)
      REG_DIV:     rd_byte = div_q;
      REG_COUNT:   rd_byte = count_q;
      REG_RELOAD:  rd_byte = reload_q;
      REG_CONTROL: rd_byte = control_q;
      default:     rd_byte = control_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_pre_q <= '0;
      div_q     <= '0;
      cnt_pre_q <= '0;
      count_q   <= '0;
      reload_q  <= '0;
      control_q <= '0;
      irq_q     <= 1'b0;
    end else begin
      if (dp_cmd_i.access && (in_beat_i.cmd == CMD_WRITE)) begin
        unique case (in_beat_i.reg_select)
          REG_DIV:     div_q     <= in_beat_i.write_byte;
          REG_COUNT:   count_q   <= in_beat_i.write_byte;
          REG_RELOAD:  reload_q  <= in_beat_i.write_byte;
          REG_CONTROL: control_q <= in_beat_i.write_byte;
          default:     control_q <= in_beat_i.write_byte;
        endcase
      end
      if (dp_cmd_i.tick_start) begin
        irq_q     <= 1'b0;
        div_pre_q <= div_pre_q + DivPreW'(in_beat_i.elapsed_cycles);
        if (enabled) begin
          cnt_pre_q <= cnt_pre_q + CntPreW'(in_beat_i.elapsed_cycles);
        end
      end
      if (dp_cmd_i.tick_step) begin
        if (div_due) begin
          div_pre_q <= div_pre_q - DivPreW'(DIV_PERIOD);
          div_q     <= div_q + 8'd1;
        end
        if (cnt_due) begin
          cnt_pre_q <= cnt_pre_q - period;
          if (count_q == 8'hFF) begin
            count_q <= reload_q;
            irq_q   <= 1'b1;
          end else begin
            count_q <= count_q + 8'd1;
          end
        end
      end
    end
  end

  // Output register: payload only, the controller owns its valid bit.
  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.access) begin
      out_q.read_byte   <= (in_beat_i.cmd == CMD_READ) ? rd_byte : 8'd0;
      out_q.irq_request <= 1'b0;
    end else if (dp_cmd_i.tick_finish) begin
      out_q.read_byte   <= 8'd0;
      out_q.irq_request <= irq_q;
    end
  end

  assign out_beat_o = out_q;

endmodule

`default_nettype wire

@@ sv/divider_and_reload_timer.sv @@
// Top level of the divider and reload timer: controller plus datapath.
// Depends on drt_pkg, drt_ctrl and drt_dp.
`default_nettype none

// The timer holds four bytes: a free-running divider, a counter, a reload
// value and a control byte (bit 2 enables the counter, bits 1:0 select a
// counter period of 1024, 16, 64 or 256 machine cycles). Each input beat is
// a tick, a register read or a register write, and every beat gives exactly
// one result beat. Reads and writes finish in the cycle they are accepted,
// so their result is registered and ready in the next cycle. A tick adds
// its elapsed cycles to the divider prescaler and, if the counter is
// enabled, to the counter prescaler, then takes one period step at a time,
// with the divider and the counter stepping side by side, until neither
// prescaler holds a full period, and then loads its result once the output
// register is free; after the period has been shortened while the prescaler
// held a large remainder, the first tick steps until it is used up. The
// counter reloads from the reload byte instead of passing 0xFF, and the
// result of such a tick carries irq_request once, however many reloads
// occurred. The output register lets a new beat be taken while a result is
// still waiting, as long as that result leaves in the same cycle.

module divider_and_reload_timer
  import drt_pkg::*;
#(
  parameter int unsigned DIV_PERIOD = DivPeriodDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_beat_t in_beat_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_beat_t     out_beat_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  drt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_cmd_i    (in_beat_i.cmd),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_cmd_o    (dp_cmd),
    .dp_status_i (dp_status)
  );

  drt_dp #(
    .DIV_PERIOD (DIV_PERIOD)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_beat_i   (in_beat_i),
    .dp_cmd_i    (dp_cmd),
    .dp_status_o (dp_status),
    .out_beat_o  (out_beat_o)
  );

  // A read, write or unused command yields its result in the next cycle.
  a_access_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_beat_i.cmd != CMD_TICK)) |=> out_valid_o)
    else $error("access beat did not produce a result in the next cycle");

  // A tick result never carries read data.
  a_irq_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.irq_request) |-> (out_beat_o.read_byte == 8'd0))
    else $error("interrupt result carries a nonzero read byte");

  // A beat is only taken when the output register can take its result.
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |-> !(out_valid_o && out_stall_i))
    else $error("input accepted while the result register is blocked");

  // Steps never run while a new beat can be accepted.
  a_step_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.tick_step |-> in_stall_o)
    else $error("tick stepping while the input is open");

endmodule

`default_nettype wire
